[src/shell_word_lexer_macros.svh]
// Assertion macros shared by the lexer modules.
`ifndef SHELL_WORD_LEXER_MACROS_SVH
`define SHELL_WORD_LEXER_MACROS_SVH
`ifndef SYNTHESIS
`define SWL_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SWL_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define SWL_ASSERT(lbl, clk, rstn, prop, msg)
`define SWL_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

[src/swl_pkg.sv]
`timescale 1ns / 1ps
package swl_pkg;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       line_end;
  } in_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] char_out;
    logic [7:0] token_total;
    logic [1:0] error_code;
    logic       last_of_run;
  } out_t;

  // One queue entry holds every result of one input byte.
  typedef struct packed {
    logic two;
    out_t res0;
    out_t res1;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  localparam logic [2:0] KIND_CHAR = 3'd0;
  localparam logic [2:0] KIND_WEND = 3'd1;
  localparam logic [2:0] KIND_PIPE = 3'd2;
  localparam logic [2:0] KIND_OK   = 3'd3;
  localparam logic [2:0] KIND_ERR  = 3'd4;

  localparam logic [1:0] ERR_BSLASH = 2'd0;
  localparam logic [1:0] ERR_SQUOTE = 2'd1;
  localparam logic [1:0] ERR_DQUOTE = 2'd2;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PIPE  = 8'h7C;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

endpackage

[src/shell_word_lexer.sv]
`timescale 1ns / 1ps
// Channel  Ports                           Payload              Direction
// in       in_valid, in_stall, in_data     swl_pkg::in_t        byte into block
// out      out_valid, out_stall, out_data  swl_pkg::out_t       result out of block
//
// One input byte is taken per cycle while the queue is not full; the lexer state is registered as each byte is taken.
// A byte yields zero, one or two results, sent one per cycle from a 4-entry queue unless out_stall holds the output.
// Sustained rate is one result per cycle, so a byte causing two results sends them one after the other.
// rst_n is synchronous; it clears lexer state, queue pointers and the output valid.
// in_stall rises only while the queue is full; out_stall holds the output register.
module shell_word_lexer #(
  parameter int MAX_TOKENS = 255
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  swl_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output swl_pkg::out_t  out_data
);

  logic              fire;
  logic              push;
  logic              pop;
  swl_pkg::entry_t   push_data;
  swl_pkg::entry_t   head;
  swl_pkg::q_stat_t  stat;

  assign in_stall = stat.full;
  assign fire     = in_valid && !stat.full;

  swl_front #(.MAX_TOKENS(MAX_TOKENS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data)
  );

  swl_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (stat)
  );

  swl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .stat      (stat),
    .pop       (pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[src/swl_front.sv]
`timescale 1ns / 1ps
`include "shell_word_lexer_macros.svh"
module swl_front #(
  parameter int MAX_TOKENS = 255
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  swl_pkg::in_t  in_data,
  output logic          push,
  output swl_pkg::entry_t push_data
);

  localparam int CAP = (MAX_TOKENS > 255) ? 255 : MAX_TOKENS;

  typedef enum logic [1:0] {
    MODE_GAP     = 2'd0,
    MODE_WORD    = 2'd1,
    MODE_COMMENT = 2'd2
  } mode_t;

  mode_t      mode_r, mode_nxt;
  logic       sq_r, sq_nxt;
  logic       dq_r, dq_nxt;
  logic       esc_r, esc_nxt;
  logic [7:0] tok_r, tok_nxt;

  logic       have;
  logic [7:0] c;
  logic       eol;
  logic       word;
  logic [7:0] t1;

  function automatic logic [7:0] sat_inc(input logic [7:0] t);
    sat_inc = (t < 8'(CAP)) ? t + 8'd1 : t;
  endfunction

  function automatic swl_pkg::out_t mk(input logic [2:0] k, input logic [7:0] ch,
                                       input logic [7:0] tot, input logic [1:0] code);
    swl_pkg::out_t r;
    r.kind        = k;
    r.char_out    = ch;
    r.token_total = tot;
    r.error_code  = code;
    r.last_of_run = 1'b0;
    mk = r;
  endfunction

  assign c    = in_data.byte_in;
  assign eol  = in_data.line_end || (c == swl_pkg::CH_NUL);
  assign word = (mode_r == MODE_WORD);
  assign t1   = sat_inc(tok_r);

  always_comb begin
    mode_nxt  = mode_r;
    sq_nxt    = sq_r;
    dq_nxt    = dq_r;
    esc_nxt   = esc_r;
    tok_nxt   = tok_r;
    have      = 1'b0;
    push_data = '0;
    if (eol) begin
      have = 1'b1;
      if (word && esc_r) begin
        push_data.res0 = mk(swl_pkg::KIND_ERR, 8'd0, 8'd0, swl_pkg::ERR_BSLASH);
      end else if (word && sq_r) begin
        push_data.res0 = mk(swl_pkg::KIND_ERR, 8'd0, 8'd0, swl_pkg::ERR_SQUOTE);
      end else if (word && dq_r) begin
        push_data.res0 = mk(swl_pkg::KIND_ERR, 8'd0, 8'd0, swl_pkg::ERR_DQUOTE);
      end else if (word) begin
        push_data.two  = 1'b1;
        push_data.res0 = mk(swl_pkg::KIND_WEND, 8'd0, 8'd0, swl_pkg::ERR_BSLASH);
        push_data.res1 = mk(swl_pkg::KIND_OK, 8'd0, t1, swl_pkg::ERR_BSLASH);
      end else begin
        push_data.res0 = mk(swl_pkg::KIND_OK, 8'd0, tok_r, swl_pkg::ERR_BSLASH);
      end
      mode_nxt = MODE_GAP;
      sq_nxt   = 1'b0;
      dq_nxt   = 1'b0;
      esc_nxt  = 1'b0;
      tok_nxt  = 8'd0;
    end else if (mode_r == MODE_COMMENT) begin
      have = 1'b0;
    end else if (word && esc_r) begin
      esc_nxt        = 1'b0;
      have           = 1'b1;
      push_data.res0 = mk(swl_pkg::KIND_CHAR, c, 8'd0, swl_pkg::ERR_BSLASH);
    end else if (word && sq_r) begin
      if (c == swl_pkg::CH_SQ) begin
        sq_nxt = 1'b0;
      end else begin
        have           = 1'b1;
        push_data.res0 = mk(swl_pkg::KIND_CHAR, c, 8'd0, swl_pkg::ERR_BSLASH);
      end
    end else if (word && dq_r) begin
      if (c == swl_pkg::CH_DQ) begin
        dq_nxt = 1'b0;
      end else if (c == swl_pkg::CH_BSL) begin
        esc_nxt = 1'b1;
      end else begin
        have           = 1'b1;
        push_data.res0 = mk(swl_pkg::KIND_CHAR, c, 8'd0, swl_pkg::ERR_BSLASH);
      end
    end else if (c == swl_pkg::CH_SPACE || (c inside {[8'd9:8'd13]}) ||
                 c == swl_pkg::CH_PIPE || c == swl_pkg::CH_HASH) begin
      if (word) begin
        have           = 1'b1;
        tok_nxt        = t1;
        mode_nxt       = MODE_GAP;
        push_data.res0 = mk(swl_pkg::KIND_WEND, 8'd0, 8'd0, swl_pkg::ERR_BSLASH);
        if (c == swl_pkg::CH_PIPE) begin
          tok_nxt        = sat_inc(t1);
          push_data.two  = 1'b1;
          push_data.res1 = mk(swl_pkg::KIND_PIPE, 8'd0, 8'd0, swl_pkg::ERR_BSLASH);
        end
      end else if (c == swl_pkg::CH_PIPE) begin
        have           = 1'b1;
        tok_nxt        = t1;
        push_data.res0 = mk(swl_pkg::KIND_PIPE, 8'd0, 8'd0, swl_pkg::ERR_BSLASH);
      end
      if (c == swl_pkg::CH_HASH) begin
        mode_nxt = MODE_COMMENT;
      end
    end else begin
      mode_nxt = MODE_WORD;
      if (c == swl_pkg::CH_SQ) begin
        sq_nxt = 1'b1;
      end else if (c == swl_pkg::CH_DQ) begin
        dq_nxt = 1'b1;
      end else if (c == swl_pkg::CH_BSL) begin
        esc_nxt = 1'b1;
      end else begin
        have           = 1'b1;
        push_data.res0 = mk(swl_pkg::KIND_CHAR, c, 8'd0, swl_pkg::ERR_BSLASH);
      end
    end
  end

  assign push = fire && have;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_GAP;
      sq_r   <= 1'b0;
      dq_r   <= 1'b0;
      esc_r  <= 1'b0;
      tok_r  <= 8'd0;
    end else if (fire) begin
      mode_r <= mode_nxt;
      sq_r   <= sq_nxt;
      dq_r   <= dq_nxt;
      esc_r  <= esc_nxt;
      tok_r  <= tok_nxt;
    end
  end

  // Quote and escape flags only live inside a word.
  `SWL_ASSERT(a_flags_in_word, clk, rst_n, (sq_r || dq_r || esc_r) |-> (mode_r == MODE_WORD), "quote or escape flag outside a word")
  `SWL_NEVER(a_one_quote, clk, rst_n, sq_r && dq_r, "both quote kinds open")

endmodule

[src/swl_fifo.sv]
`timescale 1ns / 1ps
`include "shell_word_lexer_macros.svh"
module swl_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  swl_pkg::entry_t   push_data,
  input  logic              pop,
  output swl_pkg::entry_t   head,
  output swl_pkg::q_stat_t  stat
);

  swl_pkg::entry_t                 mem_r [swl_pkg::QDEPTH];
  logic [swl_pkg::QPTR_W-1:0]      wr_r, rd_r;
  logic [swl_pkg::QCNT_W-1:0]      cnt_r;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == swl_pkg::QCNT_W'(swl_pkg::QDEPTH));
  assign head       = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  `SWL_NEVER(a_no_overflow, clk, rst_n, push && stat.full && !pop, "push into full queue")
  `SWL_NEVER(a_no_underflow, clk, rst_n, pop && stat.empty, "pop from empty queue")

endmodule

[src/swl_back.sv]
`timescale 1ns / 1ps
`include "shell_word_lexer_macros.svh"
module swl_back (
  input  logic              clk,
  input  logic              rst_n,
  input  swl_pkg::entry_t   head,
  input  swl_pkg::q_stat_t  stat,
  output logic              pop,
  input  logic              out_stall,
  output logic              out_valid,
  output swl_pkg::out_t     out_data
);

  logic          sub_r, sub_nxt;
  logic          ov_r, ov_nxt;
  swl_pkg::out_t od_r, od_nxt;
  logic          load;
  logic          take;

  assign load = !ov_r || !out_stall;
  assign take = load && !stat.empty;
  assign pop  = take && (!head.two || sub_r);

  always_comb begin
    sub_nxt = sub_r;
    ov_nxt  = ov_r;
    od_nxt  = od_r;
    if (load) begin
      ov_nxt = !stat.empty;
    end
    if (take) begin
      od_nxt             = sub_r ? head.res1 : head.res0;
      od_nxt.last_of_run = !head.two || sub_r;
      sub_nxt            = head.two && !sub_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      sub_r <= sub_nxt;
      ov_r  <= ov_nxt;
    end
    od_r <= od_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

  // A half-sent pair keeps its entry at the head of the queue.
  `SWL_ASSERT(a_sub_holds_entry, clk, rst_n, sub_r |-> (!stat.empty && head.two), "second result with no pair at head")
  `SWL_ASSERT(a_pair_first_wend, clk, rst_n, (!stat.empty && head.two) |-> (head.res0.kind == swl_pkg::KIND_WEND), "pair does not open with word end")

endmodule
